// ===== design/scaled_sprite_overlay_assert.svh =====
// Assertion macros for the controller RTL; clocked on clk, quiet while rst is high.
`ifndef SCALED_SPRITE_OVERLAY_ASSERT_SVH
`define SCALED_SPRITE_OVERLAY_ASSERT_SVH

`ifndef SYNTHESIS
`define SSO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSO_ASSERT(lbl, prop, msg)
`define SSO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/scso_pkg.sv =====
package scso_pkg;

  localparam int PIXEL_BYTES   = 4;
  localparam int PIXEL_W       = 8 * PIXEL_BYTES;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int DIM_W         = 13;
  localparam int CNT_W         = 12;
  localparam int INV_W         = 24;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = DIM_W + INV_W;
  localparam int STEP_W        = PROD_W - FRAC_W;
  localparam int BASE_W        = 2 * DIM_W;
  localparam int IDX_W         = BASE_W + 1;

  // Store depth must be a power of two: the store index wraps by dropping upper bits.
  localparam int FG_MAX_PIXELS_DEF = 4096;
  localparam int CHANNELS_DEF      = 4;

  localparam logic [DIM_W-1:0] COUNTER_SPAN = 13'd4096;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_COMPOSITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALED_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALED_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_START     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_START     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_WIDTH      = 3'd7;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SAT  = 6'b000100,
    ST_IDX  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_we;
    logic start;
    logic mul_en;
    logic sat_en;
    logic idx_en;
    logic rd_en;
    logic out_load;
  } cmd_t;

endpackage

// ===== design/scso_ram.sv =====
module scso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/scso_ctrl.sv =====
`include "scaled_sprite_overlay_assert.svh"

module scso_ctrl import scso_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   accept;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_we  = accept && (action == ACT_LOAD);
    cmd.start    = accept && (action == ACT_COMPOSITE);
    cmd.mul_en   = (state == ST_MUL);
    cmd.sat_en   = (state == ST_SAT);
    cmd.idx_en   = (state == ST_IDX);
    cmd.rd_en    = (state == ST_RD);
    cmd.out_load = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_IDX;
      ST_IDX:  state_next = ST_RD;
      ST_RD:   state_next = ST_FIN;
      ST_FIN: begin
        // hold until the output register can take the beat
        if (cmd.out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SSO_ASSERT(a_busy_not_ready, (state != ST_IDLE) |-> !in_ready, "ready while busy")
  `SSO_ASSERT_NEXT(a_fin_holds, (state == ST_FIN) && out_valid && !out_ready,
                   state == ST_FIN, "merge step left with output full")
  `SSO_ASSERT(a_valid_from_fin, $rose(out_valid) |-> $past(state == ST_FIN),
              "result beat raised outside merge step")

endmodule

// ===== design/scso_dp.sv =====
module scso_dp import scso_pkg::*; #(
  parameter int FG_MAX_PIXELS = FG_MAX_PIXELS_DEF,
  parameter int CHANNELS      = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [PIXEL_W-1:0]   pixel,
  input  logic                 first,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [PIXEL_W-1:0]   out_pixel,
  output logic                 end_of_row
);

  localparam int ADDR_W = $clog2(FG_MAX_PIXELS);

  // configuration
  logic [DIM_W-1:0] src_width, src_height, scaled_width, scaled_height;
  logic [INV_W-1:0] inv_scale;
  logic [DIM_W-1:0] row_start, col_start, bg_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= DIM_W'(1);
      src_height    <= DIM_W'(1);
      scaled_width  <= '0;
      scaled_height <= '0;
      inv_scale     <= INV_W'(65536);
      row_start     <= '0;
      col_start     <= '0;
      bg_width      <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:     src_width     <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT:    src_height    <= cfg_data[DIM_W-1:0];
        CFG_SCALED_WIDTH:  scaled_width  <= cfg_data[DIM_W-1:0];
        CFG_SCALED_HEIGHT: scaled_height <= cfg_data[DIM_W-1:0];
        CFG_INV_SCALE:     inv_scale     <= cfg_data[INV_W-1:0];
        CFG_ROW_START:     row_start     <= cfg_data[DIM_W-1:0];
        CFG_COL_START:     col_start     <= cfg_data[DIM_W-1:0];
        CFG_BG_WIDTH:      bg_width      <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // foreground load
  logic [ADDR_W-1:0] load_addr, waddr;

  assign waddr = first ? '0 : load_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_addr <= '0;
    end else if (cmd.load_we) begin
      load_addr <= (waddr == ADDR_W'(FG_MAX_PIXELS - 1)) ? '0 : waddr + ADDR_W'(1);
    end
  end

  // background position and window test
  logic [CNT_W-1:0]        bg_row, bg_col, row_cur, col_cur;
  logic signed [DIM_W:0]   dr, dc;
  logic [DIM_W-1:0]        bw, col_inc;
  logic                    eor, in_win;

  assign row_cur = first ? '0 : bg_row;
  assign col_cur = first ? '0 : bg_col;
  assign dr = $signed({2'b00, row_cur}) - $signed({row_start[DIM_W-1], row_start});
  assign dc = $signed({2'b00, col_cur}) - $signed({col_start[DIM_W-1], col_start});
  assign in_win = !dr[DIM_W] && !dc[DIM_W] &&
                  (dr[DIM_W-1:0] < scaled_height) && (dc[DIM_W-1:0] < scaled_width);

  always_comb begin
    if (bg_width == '0) begin
      bw = DIM_W'(1);
    end else if (bg_width > COUNTER_SPAN) begin
      bw = COUNTER_SPAN;
    end else begin
      bw = bg_width;
    end
  end

  assign col_inc = {1'b0, col_cur} + DIM_W'(1);
  assign eor     = (col_inc >= bw);

  logic [PIXEL_W-1:0] bg_pixel;
  logic [DIM_W-1:0]   dr_r, dc_r;
  logic               win_r, eor_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_row <= '0;
      bg_col <= '0;
    end else if (cmd.start) begin
      if (eor) begin
        bg_col <= '0;
        bg_row <= row_cur + CNT_W'(1);
      end else begin
        bg_col <= col_inc[CNT_W-1:0];
        bg_row <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bg_pixel <= pixel;
      dr_r     <= dr[DIM_W-1:0];
      dc_r     <= dc[DIM_W-1:0];
      win_r    <= in_win;
      eor_r    <= eor;
    end
  end

  // source index: scale, saturate, row base, add column
  logic [PROD_W-1:0] prod_r, prod_c;
  logic [DIM_W-1:0]  sw, sh, sr, sc;
  logic [BASE_W-1:0] row_base;
  logic [IDX_W-1:0]  idx_sum;

  assign sw = (src_width == '0) ? DIM_W'(1) : src_width;
  assign sh = (src_height == '0) ? DIM_W'(1) : src_height;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(dr_r) * PROD_W'(inv_scale);
      prod_c <= PROD_W'(dc_r) * PROD_W'(inv_scale);
    end
    if (cmd.sat_en) begin
      sr <= (prod_r[PROD_W-1:FRAC_W] > STEP_W'(sh - DIM_W'(1))) ?
            sh - DIM_W'(1) : prod_r[FRAC_W+DIM_W-1:FRAC_W];
      sc <= (prod_c[PROD_W-1:FRAC_W] > STEP_W'(sw - DIM_W'(1))) ?
            sw - DIM_W'(1) : prod_c[FRAC_W+DIM_W-1:FRAC_W];
    end
    if (cmd.idx_en) begin
      row_base <= BASE_W'(sr) * BASE_W'(sw);
    end
  end

  assign idx_sum = IDX_W'(row_base) + IDX_W'(sc);

  logic [PIXEL_W-1:0] fg_pixel;

  scso_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (FG_MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (waddr),
    .wdata (pixel),
    .re    (cmd.rd_en),
    .raddr (idx_sum[ADDR_W-1:0]),
    .rdata (fg_pixel)
  );

  // color key merge: a zero foreground byte lets the background through
  logic [PIXEL_W-1:0] merged;

  always_comb begin
    merged = bg_pixel;
    for (int b = 0; b < PIXEL_BYTES; b++) begin
      if (b < CHANNELS && win_r && fg_pixel[8*b +: 8] != 8'h00) begin
        merged[8*b +: 8] = fg_pixel[8*b +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel  <= merged;
      end_of_row <= eor_r;
    end
  end

endmodule

// ===== design/scaled_sprite_overlay.sv =====
// channel  | handshake            | payload
// input    | in_valid / in_ready  | action, pixel, first
// output   | out_valid / out_ready| out_pixel, end_of_row
// config   | cfg_we               | cfg_index, cfg_data
//
// Loads stream back to back into the foreground store. A composite beat runs through
// accept, scale multiply, saturate, row-base multiply, registered store read and merge;
// the sequencer walks these one item at a time. Reset is synchronous: counters,
// configuration and control state return to defaults; data registers and store stay.
// A finished pixel waits in the output register; the block takes the next beat meanwhile
// and holds the following composite in its merge step until that register frees up.
module scaled_sprite_overlay import scso_pkg::*; #(
  parameter int FG_MAX_PIXELS = FG_MAX_PIXELS_DEF,
  parameter int CHANNELS      = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [PIXEL_W-1:0]   pixel,
  input  logic                 first,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIXEL_W-1:0]   out_pixel,
  output logic                 end_of_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;

  scso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  scso_dp #(
    .FG_MAX_PIXELS (FG_MAX_PIXELS),
    .CHANNELS      (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .pixel      (pixel),
    .first      (first),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_pixel  (out_pixel),
    .end_of_row (end_of_row)
  );

endmodule

// ===== bench/scaled_sprite_overlay_checker.sv =====
`timescale 1ns / 1ps

module scaled_sprite_overlay_checker import scso_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 action,
  input  logic [PIXEL_W-1:0]   pixel,
  input  logic                 first,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [PIXEL_W-1:0]   out_pixel,
  input  logic                 end_of_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int FG_DEPTH   = FG_MAX_PIXELS_DEF;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [PIXEL_W-1:0] pix;
    logic               eor;
  } overlay_beat_t;

  overlay_beat_t      expected_pixels[$];
  logic [PIXEL_W-1:0] fg_mem [FG_DEPTH];
  logic [CNT_W-1:0]   load_ptr;
  logic [CNT_W-1:0]   row_pos;
  logic [CNT_W-1:0]   col_pos;
  logic [DIM_W-1:0]   src_w_r, src_h_r, win_w_r, win_h_r;
  logic [DIM_W-1:0]   row_off_r, col_off_r, bg_w_r;
  logic [INV_W-1:0]   inv_r;
  int                 results_seen;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic log_fault(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORT) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Window offset to source index: floor(off * inv_scale), clamped to size - 1.
  function automatic logic [DIM_W-1:0] nearest_src(input int off, input int size);
    logic [63:0] prod;
    int          lim;
    prod = (64'(off) * 64'(inv_r)) >> FRAC_W;
    lim  = size - 1;
    return (prod > 64'(lim)) ? DIM_W'(lim) : prod[DIM_W-1:0];
  endfunction

  task automatic predict_overlay(input logic [PIXEL_W-1:0] bg, input logic restart);
    int                 eff_bw, eff_sw, eff_sh;
    int                 ro, co, dr, dc;
    logic [DIM_W-1:0]   sr, sc;
    logic [63:0]        flat;
    logic [PIXEL_W-1:0] fg;
    overlay_beat_t      beat;
    if (restart) begin
      row_pos = '0;
      col_pos = '0;
    end
    eff_bw = (bg_w_r == '0) ? 1 : ((bg_w_r > COUNTER_SPAN) ? int'(COUNTER_SPAN) : int'(bg_w_r));
    eff_sw = (src_w_r == '0) ? 1 : int'(src_w_r);
    eff_sh = (src_h_r == '0) ? 1 : int'(src_h_r);
    ro = $signed(row_off_r);
    co = $signed(col_off_r);
    dr = int'(row_pos) - ro;
    dc = int'(col_pos) - co;
    beat.pix = bg;
    if (dr >= 0 && dc >= 0 && dr < int'(win_h_r) && dc < int'(win_w_r)) begin
      sr   = nearest_src(dr, eff_sh);
      sc   = nearest_src(dc, eff_sw);
      flat = 64'(sr) * 64'(eff_sw) + 64'(sc);
      fg   = fg_mem[int'(flat % FG_DEPTH)];
      // zero bytes are the color key: keep the background there
      for (int ch = 0; ch < CHANNELS_DEF && ch < PIXEL_BYTES; ch++)
        if (fg[8*ch +: 8] != 8'h00) beat.pix[8*ch +: 8] = fg[8*ch +: 8];
    end
    beat.eor = (int'(col_pos) + 1 >= eff_bw);
    if (beat.eor) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    expected_pixels.push_back(beat);
  endtask

  always @(posedge clk) begin
    overlay_beat_t want;
    if (rst) begin
      expected_pixels.delete();
      load_ptr  = '0;
      row_pos   = '0;
      col_pos   = '0;
      src_w_r   = DIM_W'(1);
      src_h_r   = DIM_W'(1);
      win_w_r   = '0;
      win_h_r   = '0;
      inv_r     = INV_W'(65536);
      row_off_r = '0;
      col_off_r = '0;
      bg_w_r    = DIM_W'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:     src_w_r   = cfg_data[DIM_W-1:0];
          CFG_SRC_HEIGHT:    src_h_r   = cfg_data[DIM_W-1:0];
          CFG_SCALED_WIDTH:  win_w_r   = cfg_data[DIM_W-1:0];
          CFG_SCALED_HEIGHT: win_h_r   = cfg_data[DIM_W-1:0];
          CFG_INV_SCALE:     inv_r     = cfg_data[INV_W-1:0];
          CFG_ROW_START:     row_off_r = cfg_data[DIM_W-1:0];
          CFG_COL_START:     col_off_r = cfg_data[DIM_W-1:0];
          CFG_BG_WIDTH:      bg_w_r    = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          log_fault($sformatf("result %0d arrived with nothing expected (%08h)",
                              results_seen, out_pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want.pix)
            log_fault($sformatf("result %0d out_pixel expected %08h got %08h",
                                results_seen, want.pix, out_pixel));
          if (end_of_row !== want.eor)
            log_fault($sformatf("result %0d end_of_row expected %0b got %0b",
                                results_seen, want.eor, end_of_row));
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) begin
          if (first) load_ptr = '0;
          fg_mem[load_ptr] = pixel;
          load_ptr = load_ptr + 1'b1;
        end else begin
          predict_overlay(pixel, first);
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== bench/tb_scaled_sprite_overlay.sv =====
`timescale 1ns / 1ps

module tb_scaled_sprite_overlay;
  import scso_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int FILL_ENTRIES = 128;

  // sender idle styles
  localparam int GAP_NORMAL = 0;
  localparam int GAP_QUICK  = 1;
  localparam int GAP_NONE   = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_LOAD;
  logic [PIXEL_W-1:0]   pixel = '0;
  logic                 first = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIXEL_W-1:0]   out_pixel;
  logic                 end_of_row;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int loads_sent = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  int settings_used = 0;
  int holds_done = 0;
  bit hold_output = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count++;

  scaled_sprite_overlay uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .pixel      (pixel),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .end_of_row (end_of_row),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  scaled_sprite_overlay_checker overlay_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .pixel       (pixel),
    .first       (first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .end_of_row  (end_of_row),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver: random ready runs, plus a long hold-off whenever the sender asks.
  initial begin
    int  run_left;
    int  r;
    logic level;
    run_left = 0;
    level    = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_output = 1'b0;
        holds_done++;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(99);
          if (r < 65) begin
            level    = 1'b1;
            run_left = $urandom_range(24, 1);
          end else if (r < 92) begin
            level    = 1'b0;
            run_left = $urandom_range(3, 1);
          end else begin
            level    = 1'b0;
            run_left = $urandom_range(30, 8);
          end
        end
        out_ready <= level;
        run_left--;
      end
    end
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] p;
    for (int b = 0; b < PIXEL_BYTES; b++)
      p[8*b +: 8] = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255));
    return p;
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(99);
    if (mode == GAP_NONE) return 0;
    if (mode == GAP_QUICK) return (r < 70) ? 0 : $urandom_range(2, 1);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [DIM_W-1:0] pick_span(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return COUNTER_SPAN;
    if (r < 16) return DIM_W'($urandom_range(8191, 4097));
    return DIM_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [DIM_W-1:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 8) return DIM_W'(-4096);
    if (r < 16) return DIM_W'(4095);
    if (r < 24) return DIM_W'($urandom());
    return DIM_W'(int'($urandom_range(9)) - 3);
  endfunction

  function automatic logic [INV_W-1:0] pick_inv();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 38) return INV_W'(65536);
    if (r < 48) return INV_W'($urandom());
    return INV_W'($urandom_range(32'h40000, 32'h2000));
  endfunction

  // Upper bound of the store index over the whole window; keep it in the filled entries.
  function automatic bit reads_in_fill(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                       input logic [DIM_W-1:0] ww, input logic [DIM_W-1:0] wh,
                                       input logic [INV_W-1:0] inv);
    longint eff_sw, eff_sh, r_max, c_max;
    if (ww == '0 || wh == '0) return 1'b1;
    eff_sw = longint'(sw);
    if (eff_sw == 0) eff_sw = 1;
    eff_sh = longint'(sh);
    if (eff_sh == 0) eff_sh = 1;
    r_max = ((longint'(wh) - 1) * longint'(inv)) >>> FRAC_W;
    c_max = ((longint'(ww) - 1) * longint'(inv)) >>> FRAC_W;
    if (r_max > eff_sh - 1) r_max = eff_sh - 1;
    if (c_max > eff_sw - 1) c_max = eff_sw - 1;
    return (r_max * eff_sw + c_max) < FILL_ENTRIES;
  endfunction

  // 13-bit registers get random junk above bit 12
  function automatic logic [CFG_W-1:0] pad_dim(input logic [DIM_W-1:0] v);
    logic [CFG_W-DIM_W-1:0] junk;
    junk = (CFG_W-DIM_W)'($urandom());
    return {junk, v};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic program_overlay(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                 input logic [DIM_W-1:0] ww, input logic [DIM_W-1:0] wh,
                                 input logic [INV_W-1:0] inv, input logic [DIM_W-1:0] ro,
                                 input logic [DIM_W-1:0] co, input logic [DIM_W-1:0] bw);
    write_reg(CFG_SRC_WIDTH, pad_dim(sw));
    write_reg(CFG_SRC_HEIGHT, pad_dim(sh));
    write_reg(CFG_SCALED_WIDTH, pad_dim(ww));
    write_reg(CFG_SCALED_HEIGHT, pad_dim(wh));
    write_reg(CFG_INV_SCALE, CFG_W'(inv));
    write_reg(CFG_ROW_START, pad_dim(ro));
    write_reg(CFG_COL_START, pad_dim(co));
    write_reg(CFG_BG_WIDTH, pad_dim(bw));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_beat(input logic act, input logic [PIXEL_W-1:0] pix, input logic fst);
    in_valid <= 1'b1;
    action   <= act;
    pixel    <= pix;
    first    <= fst;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_LOAD) loads_sent++;
    else pixels_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap(input int mode);
    int n;
    n = pick_gap(mode);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every result, then let any trailing load beat retire.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int mode, input int n_loads, input int n_pixels,
                           input bit clean);
    logic fst;
    for (int i = 0; i < n_loads; i++) begin
      fst = (i == 0) ? ($urandom_range(3) != 0) : (!clean && $urandom_range(49) == 0);
      send_beat(ACT_LOAD, rand_pixel(), fst);
      sender_gap(mode);
    end
    for (int i = 0; i < n_pixels; i++) begin
      if (!clean && $urandom_range(99) < 5) begin
        send_beat(ACT_LOAD, rand_pixel(), $urandom_range(3) == 0);
        sender_gap(mode);
      end
      fst = (i == 0) ? (clean || $urandom_range(9) < 7) : (!clean && $urandom_range(39) == 0);
      send_beat(ACT_COMPOSITE, rand_pixel(), fst);
      sender_gap(mode);
    end
  endtask

  initial begin
    logic [PIXEL_W-1:0] fg_seed [4];
    logic [PIXEL_W-1:0] bg;
    logic [DIM_W-1:0]   p_sw, p_sh, p_ww, p_wh;
    logic [INV_W-1:0]   p_inv;
    int                 mode;
    int                 random_items;
    int                 rnd_phase;
    int                 before_count;
    int                 n_pixels;

    fg_seed[0] = 32'h1122_3344;
    fg_seed[1] = 32'h00FF_0000;
    fg_seed[2] = 32'hFFFF_FFFF;
    fg_seed[3] = 32'h0000_0000;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 2x2 sprite at (1,1), scale 4/3: column offset 3 saturates to the last source column
    program_overlay(DIM_W'(2), DIM_W'(2), DIM_W'(4), DIM_W'(4), INV_W'(32'hC000),
                    DIM_W'(1), DIM_W'(1), DIM_W'(5));
    for (int i = 0; i < 4; i++) begin
      send_beat(ACT_LOAD, fg_seed[i], i == 0);
      sender_gap(GAP_NORMAL);
    end
    for (int i = 0; i < 20; i++) begin
      case (i % 3)
        0:       bg = 32'hFFFF_FFFF;
        1:       bg = 32'h0000_0000;
        default: bg = $urandom();
      endcase
      // restart the position counters mid-row near the end
      send_beat(ACT_COMPOSITE, bg, i == 0 || i == 18);
      sender_gap(GAP_NORMAL);
    end
    settle();

    // fill the low store entries that every later window reads from
    run_phase(GAP_QUICK, FILL_ENTRIES, 0, 1'b1);
    settle();

    // largest window and scale step, most negative offsets: every window pixel saturates
    // to the last pixel of an 8x16 source
    program_overlay(DIM_W'(8), DIM_W'(16), DIM_W'(8191), DIM_W'(8191), '1,
                    DIM_W'(-4096), DIM_W'(-4096), COUNTER_SPAN);
    run_phase(GAP_NORMAL, 0, 40, 1'b0);
    settle();

    // lowest settings: zero sizes treated as one, zero scale, one-pixel rows
    program_overlay('0, '0, DIM_W'(5), DIM_W'(5), '0, '0, '0, '0);
    run_phase(GAP_NORMAL, 2, 12, 1'b0);
    settle();

    random_items = 0;
    rnd_phase    = 0;
    while (random_items < RANDOM_ITEMS) begin
      do begin
        p_sw  = pick_span(1, 8);
        p_sh  = pick_span(1, 8);
        p_ww  = pick_span(0, 12);
        p_wh  = pick_span(0, 12);
        p_inv = pick_inv();
      end while (!reads_in_fill(p_sw, p_sh, p_ww, p_wh, p_inv));
      program_overlay(p_sw, p_sh, p_ww, p_wh, p_inv, pick_offset(), pick_offset(),
                      pick_span(1, 12));
      before_count = loads_sent + pixels_sent;
      case ($urandom_range(19))
        0, 1, 2:       mode = GAP_QUICK;
        3, 4, 5, 6, 7: mode = GAP_NONE;
        default:       mode = GAP_NORMAL;
      endcase
      n_pixels = $urandom_range(60, 10);
      if (rnd_phase % 9 == 0) begin
        // back up the output so the block fills and stalls its input
        hold_output = 1'b1;
        mode        = GAP_NONE;
        n_pixels    = 60;
      end
      run_phase(mode, $urandom_range(8), n_pixels, 1'b0);
      settle();
      random_items += loads_sent + pixels_sent - before_count;
      rnd_phase++;
    end

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d foreground loads and %0d composited pixels over %0d settings",
             loads_sent, pixels_sent, settings_used);
    $display("%0d register writes, %0d long output hold-offs, %0d cycles",
             cfg_writes, holds_done, cycle_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== scaled_sprite_overlay.f =====
+incdir+design
design/scso_pkg.sv
design/scso_ram.sv
design/scso_ctrl.sv
design/scso_dp.sv
design/scaled_sprite_overlay.sv
bench/scaled_sprite_overlay_checker.sv
bench/tb_scaled_sprite_overlay.sv
